// ===== sv/swds_pkg.sv =====
// Shared types, register indexes and constants of the stepper wave-drive sequencer.
package swds_pkg;

	localparam int unsigned StepCountW = 10;
	localparam int unsigned PeriodW    = 8;
	localparam int unsigned TicksW     = 12;
	localparam int unsigned CfgIndexW  = 3;
	localparam int unsigned CfgDataW   = 12;
	localparam int unsigned PatternW   = 5;
	localparam int unsigned SegmentW   = 3;
	localparam int unsigned PhaseW     = 3;
	localparam int unsigned ModeW      = 2;

	// Register indexes of the configuration port.
	localparam logic [CfgIndexW-1:0] REG_WASH_STEP_COUNT = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_SPIN_STEP_COUNT = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_WASH_PERIOD     = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_SPIN1_PERIOD    = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_SPIN2_PERIOD    = 3'd4;
	localparam logic [CfgIndexW-1:0] REG_PAUSE_TICKS     = 3'd5;
	localparam logic [CfgIndexW-1:0] REG_STARTUP_TICKS   = 3'd6;

	// Register values after reset.
	localparam logic [StepCountW-1:0] WASH_STEP_COUNT_RST = 10'd400;
	localparam logic [StepCountW-1:0] SPIN_STEP_COUNT_RST = 10'd800;
	localparam logic [PeriodW-1:0]    WASH_PERIOD_RST     = 8'd30;
	localparam logic [PeriodW-1:0]    SPIN1_PERIOD_RST    = 8'd20;
	localparam logic [PeriodW-1:0]    SPIN2_PERIOD_RST    = 8'd10;
	localparam logic [TicksW-1:0]     PAUSE_TICKS_RST     = 12'd1000;
	localparam logic [TicksW-1:0]     STARTUP_TICKS_RST   = 12'd2000;

	// Sequencer modes.
	localparam logic [ModeW-1:0] MODE_STARTUP = 2'd0;
	localparam logic [ModeW-1:0] MODE_IDLE    = 2'd1;
	localparam logic [ModeW-1:0] MODE_STEP    = 2'd2;
	localparam logic [ModeW-1:0] MODE_PAUSE   = 2'd3;

	localparam logic [PatternW-1:0] IDLE_PATTERN = 5'b10000;
	localparam logic [SegmentW-1:0] LAST_SEGMENT = 3'd5;

	typedef struct packed {
		logic start_n;
		logic stop_n;
	} item_t;

	typedef struct packed {
		logic [PatternW-1:0] coil_pattern;
		logic                running;
		logic [SegmentW-1:0] segment;
	} result_t;

	typedef struct packed {
		logic [StepCountW-1:0] wash_step_count;
		logic [StepCountW-1:0] spin_step_count;
		logic [PeriodW-1:0]    wash_period;
		logic [PeriodW-1:0]    spin1_period;
		logic [PeriodW-1:0]    spin2_period;
		logic [TicksW-1:0]     pause_ticks;
		logic [TicksW-1:0]     startup_ticks;
	} cfg_t;

	typedef struct packed {
		logic [ModeW-1:0]      mode;
		logic [PhaseW-1:0]     coil_phase;
		logic [SegmentW-1:0]   segment_index;
		logic [StepCountW-1:0] steps_done;
		logic [TicksW-1:0]     tick_timer;
		logic [PatternW-1:0]   drive_latch;
	} seq_state_t;

endpackage

// ===== sv/stepper_wave_drive_sequencer.sv =====
// Top level of the stepper wave-drive sequencer: registers, handshakes and configuration.
// Each accepted beat is one 1 ms tick carrying the start and stop button levels, and it
// produces exactly one result beat with the coil pattern, the running flag and the segment.
// The sequencer state and the result register are both updated at the edge that accepts
// a tick, so with result_ready held high a new tick can be accepted on every cycle. The
// single result register decides the rate; while it holds a beat that has not been taken,
// item_ready is low. Configuration writes take effect at once and should only be made
// while no tick is in flight.
module stepper_wave_drive_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  swds_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output swds_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [swds_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [swds_pkg::CfgDataW-1:0]     cfg_data
);

	swds_pkg::cfg_t       cfg_q;
	swds_pkg::seq_state_t state_q;
	swds_pkg::seq_state_t state_nxt;
	swds_pkg::result_t    result_nxt;
	swds_pkg::result_t    result_q;
	logic                 result_valid_q;
	logic                 accept;

	assign item_ready   = !result_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wash_step_count <= swds_pkg::WASH_STEP_COUNT_RST;
			cfg_q.spin_step_count <= swds_pkg::SPIN_STEP_COUNT_RST;
			cfg_q.wash_period     <= swds_pkg::WASH_PERIOD_RST;
			cfg_q.spin1_period    <= swds_pkg::SPIN1_PERIOD_RST;
			cfg_q.spin2_period    <= swds_pkg::SPIN2_PERIOD_RST;
			cfg_q.pause_ticks     <= swds_pkg::PAUSE_TICKS_RST;
			cfg_q.startup_ticks   <= swds_pkg::STARTUP_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swds_pkg::REG_WASH_STEP_COUNT:
					cfg_q.wash_step_count <= cfg_data[swds_pkg::StepCountW-1:0];
				swds_pkg::REG_SPIN_STEP_COUNT:
					cfg_q.spin_step_count <= cfg_data[swds_pkg::StepCountW-1:0];
				swds_pkg::REG_WASH_PERIOD:
					cfg_q.wash_period <= cfg_data[swds_pkg::PeriodW-1:0];
				swds_pkg::REG_SPIN1_PERIOD:
					cfg_q.spin1_period <= cfg_data[swds_pkg::PeriodW-1:0];
				swds_pkg::REG_SPIN2_PERIOD:
					cfg_q.spin2_period <= cfg_data[swds_pkg::PeriodW-1:0];
				swds_pkg::REG_PAUSE_TICKS:
					cfg_q.pause_ticks <= cfg_data;
				swds_pkg::REG_STARTUP_TICKS:
					cfg_q.startup_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	swds_step u_step (
		.cfg    (cfg_q),
		.cur    (state_q),
		.item   (item),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= swds_pkg::MODE_STARTUP;
			state_q.coil_phase    <= '0;
			state_q.segment_index <= '0;
			state_q.steps_done    <= '0;
			state_q.tick_timer    <= '0;
			state_q.drive_latch   <= '0;
			result_valid_q        <= 1'b0;
		end else begin
			if (accept) begin
				state_q        <= state_nxt;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_nxt;
		end
	end

endmodule

// ===== sv/swds_step.sv =====
// Next-state and result logic for one tick of the stepper wave-drive sequencer.
module swds_step (
	input  swds_pkg::cfg_t       cfg,
	input  swds_pkg::seq_state_t cur,
	input  swds_pkg::item_t      item,
	output swds_pkg::seq_state_t nxt,
	output swds_pkg::result_t    result
);

	logic                                do_idle;
	logic                                do_begin;
	logic                                do_step;
	logic [swds_pkg::SegmentW-1:0]       begin_seg;
	logic [swds_pkg::StepCountW-1:0]     steps_inc;
	logic [swds_pkg::StepCountW-1:0]     seg_count;
	logic [swds_pkg::PeriodW-1:0]        seg_period;
	logic                                pause_after;
	logic [swds_pkg::TicksW-1:0]         timer_inc;
	logic                                run;

	assign steps_inc = cur.steps_done + 1'b1;
	assign timer_inc = cur.tick_timer + 1'b1;

	always_comb begin
		if (cur.segment_index < 3'd2) begin
			seg_count  = cfg.wash_step_count;
			seg_period = cfg.wash_period;
		end else begin
			seg_count  = cfg.spin_step_count;
			seg_period = (cur.segment_index < 3'd4) ? cfg.spin1_period : cfg.spin2_period;
		end
		// A step count of zero behaves as a single step.
		if (seg_count == '0) begin
			seg_count = {{(swds_pkg::StepCountW-1){1'b0}}, 1'b1};
		end
	end

	assign pause_after = (cur.segment_index == 3'd0) || (cur.segment_index == 3'd1) ||
		(cur.segment_index == 3'd2) || (cur.segment_index == 3'd4);

	always_comb begin
		nxt       = cur;
		do_idle   = 1'b0;
		do_begin  = 1'b0;
		do_step   = 1'b0;
		begin_seg = cur.segment_index + 1'b1;

		unique case (cur.mode)
			swds_pkg::MODE_STARTUP: begin
				if (cur.tick_timer >= cfg.startup_ticks) begin
					do_idle = 1'b1;
				end else begin
					nxt.tick_timer = timer_inc;
				end
			end
			swds_pkg::MODE_IDLE: begin
				do_idle = 1'b1;
			end
			swds_pkg::MODE_STEP: begin
				if (cur.tick_timer < {{(swds_pkg::TicksW-swds_pkg::PeriodW){1'b0}}, seg_period})
				begin
					nxt.tick_timer = timer_inc;
				end else begin
					nxt.steps_done = steps_inc;
					if (!item.stop_n) begin
						do_idle = 1'b1;
					end else if (steps_inc < seg_count) begin
						do_step = 1'b1;
					end else if (cur.segment_index >= swds_pkg::LAST_SEGMENT) begin
						do_idle = 1'b1;
					end else if (pause_after) begin
						// The rest's first tick is counted on this same tick.
						nxt.mode = swds_pkg::MODE_PAUSE;
						if (cfg.pause_ticks == '0) begin
							do_begin = 1'b1;
						end else begin
							nxt.tick_timer = {{(swds_pkg::TicksW-1){1'b0}}, 1'b1};
						end
					end else begin
						do_begin = 1'b1;
					end
				end
			end
			swds_pkg::MODE_PAUSE: begin
				if (cur.tick_timer >= cfg.pause_ticks) begin
					do_begin = 1'b1;
				end else begin
					nxt.tick_timer = timer_inc;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase

		if (do_idle) begin
			nxt.mode          = swds_pkg::MODE_IDLE;
			nxt.segment_index = '0;
			nxt.steps_done    = '0;
			nxt.tick_timer    = '0;
			nxt.drive_latch   = swds_pkg::IDLE_PATTERN;
			if (!item.start_n) begin
				do_begin  = 1'b1;
				begin_seg = '0;
			end
		end

		if (do_begin) begin
			nxt.segment_index = begin_seg;
			nxt.steps_done    = '0;
			do_step           = 1'b1;
		end

		if (do_step) begin
			// Even segments run forward, odd ones in reverse, wrapping over four phases.
			if (!nxt.segment_index[0]) begin
				nxt.coil_phase = (cur.coil_phase >= 3'd4) ? 3'd1 : cur.coil_phase + 1'b1;
			end else begin
				nxt.coil_phase = (cur.coil_phase <= 3'd1) ? 3'd4 : cur.coil_phase - 1'b1;
			end
			nxt.drive_latch = swds_pkg::PatternW'(1) << (nxt.coil_phase - 1'b1);
			nxt.tick_timer  = {{(swds_pkg::TicksW-1){1'b0}}, 1'b1};
			nxt.mode        = swds_pkg::MODE_STEP;
		end
	end

	assign run = (nxt.mode == swds_pkg::MODE_STEP) || (nxt.mode == swds_pkg::MODE_PAUSE);

	assign result.coil_pattern = nxt.drive_latch;
	assign result.running      = run;
	assign result.segment      = run ? nxt.segment_index : '0;

endmodule
